// ===== rtl/core/lpht_pkg.sv =====
// Package for the linear-probing hash table core.
// Field widths, operation and status codes, and the remainder unit status type.
// No dependencies.
package lpht_pkg;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 31;
    localparam int PAY_W   = 32;
    localparam int ST_W    = 2;
    localparam int SIZE_W  = 9;
    localparam int SLOT_W  = 8;
    localparam int OCC_W   = 9;

    // table word: occupied mark, key, payload
    localparam int ENTRY_W = 1 + KEY_W + PAY_W;

    // remainder unit: dividend padded to an even width, two bits retired per step
    localparam int DVD_W     = KEY_W + 1;
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_status;

endpackage

// ===== rtl/core/lpht_rem.sv =====
// Iterative remainder unit: key modulo table size, two bits per cycle.
// Depends on lpht_pkg.
module lpht_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lpht_pkg::KEY_W-1:0]    i_dividend,
    input  logic [lpht_pkg::SIZE_W-1:0]   i_divisor,
    output lpht_pkg::t_rem_status         o_status,
    output logic [lpht_pkg::SIZE_W-1:0]   o_rem
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [lpht_pkg::STEP_W-1:0]       r_step, n_step;
    logic [lpht_pkg::DVD_W-1:0]        r_dvd, n_dvd;
    logic [lpht_pkg::SIZE_W-1:0]       r_rem, n_rem;
    logic [lpht_pkg::SIZE_W-1:0]       r_div, n_div;

    logic [lpht_pkg::SIZE_W:0]         t1, t2, dw;
    logic [lpht_pkg::SIZE_W-1:0]       rem1, rem2;

    // two restoring steps; the partial remainder stays below the divisor
    always_comb begin
        dw   = {1'b0, r_div};
        t1   = {r_rem, r_dvd[lpht_pkg::DVD_W-1]};
        if (t1 >= dw) begin
            t1 = t1 - dw;
        end
        rem1 = t1[lpht_pkg::SIZE_W-1:0];
        t2   = {rem1, r_dvd[lpht_pkg::DVD_W-2]};
        if (t2 >= dw) begin
            t2 = t2 - dw;
        end
        rem2 = t2[lpht_pkg::SIZE_W-1:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_dvd  = {1'b0, i_dividend};
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = rem2;
            n_dvd  = {r_dvd[lpht_pkg::DVD_W-3:0], 2'b00};
            n_step = r_step + 1'b1;
            if (r_step == lpht_pkg::STEP_W'(lpht_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_rem         = r_rem;

endmodule

// ===== rtl/core/lpht_ram.sv =====
// Single-port slot memory with registered read data.
// No dependencies.
module lpht_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/linear_probe_hash_table_core.sv =====
// Linear-probing hash table core: top level with the request sequencer.
// Depends on lpht_pkg, lpht_rem and lpht_ram.
//
// One request transaction (insert, delete or search) is taken at a time; the
// input side stalls until the request has finished and its result has moved
// into the output register. A request is accepted, then the remainder unit
// finds the home slot (key modulo table size, two quotient bits a cycle over
// 16 steps, then a done report); each slot probed takes a memory read, then a
// compare and write-back through the single table port, and the result is then
// handed over. Probes number between 1 and the effective table size. Delete
// and search on an empty table, and the unused opcode, skip the remainder and
// probe steps. After reset a clearing pass over every slot wipes the occupied
// marks; the input stays stalled until it ends, while table_size writes are
// taken throughout. A table_size of zero acts as one and one above MAX_SLOTS
// acts as MAX_SLOTS. Delete and search walks never stop at a free slot, and a
// miss covers the whole effective table, so deletes need no tombstones. The
// result register lets a new request in while an old result is still waiting
// to be taken.
module linear_probe_hash_table_core #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [lpht_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lpht_pkg::OP_W-1:0]     i_opcode,
    input  logic [lpht_pkg::KEY_W-1:0]    i_key,
    input  logic [lpht_pkg::PAY_W-1:0]    i_payload_in,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lpht_pkg::ST_W-1:0]     o_status,
    output logic [lpht_pkg::PAY_W-1:0]    o_payload_out,
    output logic [lpht_pkg::SLOT_W-1:0]   o_slot,
    output logic [lpht_pkg::OCC_W-1:0]    o_occupied
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int CMP_W  = ((IDX_W > lpht_pkg::SIZE_W) ? IDX_W : lpht_pkg::SIZE_W) + 1;
    localparam int CNT_RAW = $clog2(MAX_SLOTS + 1);
    localparam int CNT_W  = (CNT_RAW > lpht_pkg::OCC_W) ? CNT_RAW : lpht_pkg::OCC_W;
    localparam logic [16:0] MAX_WIDE = 17'(MAX_SLOTS);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // control state
    logic [2:0]                       r_state, n_state;
    logic [lpht_pkg::SIZE_W-1:0]      r_table_size, n_table_size;
    logic [CNT_W-1:0]                 r_count, n_count;
    logic                             r_out_valid, n_out_valid;
    // request context
    logic [lpht_pkg::OP_W-1:0]        r_op, n_op;
    logic [lpht_pkg::KEY_W-1:0]       r_key, n_key;
    logic [lpht_pkg::PAY_W-1:0]       r_pay, n_pay;
    logic [lpht_pkg::SIZE_W-1:0]      r_size, n_size;
    logic [lpht_pkg::SIZE_W-1:0]      r_left, n_left;
    logic [IDX_W-1:0]                 r_idx, n_idx;
    // pending result and output register
    logic [lpht_pkg::ST_W-1:0]        r_res_status, n_res_status;
    logic [lpht_pkg::PAY_W-1:0]       r_res_pay, n_res_pay;
    logic [lpht_pkg::SLOT_W-1:0]      r_res_slot, n_res_slot;
    logic [lpht_pkg::ST_W-1:0]        r_out_status, n_out_status;
    logic [lpht_pkg::PAY_W-1:0]       r_out_pay, n_out_pay;
    logic [lpht_pkg::SLOT_W-1:0]      r_out_slot, n_out_slot;
    logic [lpht_pkg::OCC_W-1:0]       r_out_occ, n_out_occ;

    logic                             in_take, out_take;
    logic [lpht_pkg::SIZE_W-1:0]      eff_size;
    logic [16:0]                      ts_wide;
    logic                             rem_start;
    lpht_pkg::t_rem_status            rem_st;
    logic [lpht_pkg::SIZE_W-1:0]      rem_val;
    logic [CMP_W-1:0]                 rem_w, idx_w, idx_inc, size_w;
    logic [IDX_W-1:0]                 idx_next;
    logic                             ram_we, ram_re;
    logic [lpht_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;
    logic                             rd_occ, hit;
    logic [lpht_pkg::KEY_W-1:0]       rd_key;
    logic [lpht_pkg::PAY_W-1:0]       rd_pay;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;

    // clamp the configured size into 1 .. MAX_SLOTS
    assign ts_wide = {8'd0, r_table_size};
    always_comb begin
        if (r_table_size == '0) begin
            eff_size = lpht_pkg::SIZE_W'(1);
        end else if (ts_wide > MAX_WIDE) begin
            eff_size = lpht_pkg::SIZE_W'(MAX_SLOTS);
        end else begin
            eff_size = r_table_size;
        end
    end

    // home slot = key mod size
    lpht_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (i_key),
        .i_divisor  (eff_size),
        .o_status   (rem_st),
        .o_rem      (rem_val)
    );

    lpht_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (lpht_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (r_idx),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // slot index arithmetic on a common width
    assign rem_w    = CMP_W'(rem_val);
    assign idx_w    = CMP_W'(r_idx);
    assign size_w   = CMP_W'(r_size);
    assign idx_inc  = idx_w + CMP_W'(1);
    assign idx_next = (idx_inc == size_w) ? '0 : idx_inc[IDX_W-1:0];

    assign rd_occ = ram_rdata[lpht_pkg::ENTRY_W-1];
    assign rd_key = ram_rdata[lpht_pkg::PAY_W +: lpht_pkg::KEY_W];
    assign rd_pay = ram_rdata[lpht_pkg::PAY_W-1:0];
    // insert wants a free slot, delete/search a live entry with the key
    assign hit    = (r_op == lpht_pkg::OP_INSERT) ? !rd_occ : (rd_occ && (rd_key == r_key));

    always_comb begin
        n_state      = r_state;
        n_table_size = r_table_size;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_key        = r_key;
        n_pay        = r_pay;
        n_size       = r_size;
        n_left       = r_left;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_pay    = r_res_pay;
        n_res_slot   = r_res_slot;
        n_out_status = r_out_status;
        n_out_pay    = r_out_pay;
        n_out_slot   = r_out_slot;
        n_out_occ    = r_out_occ;
        rem_start    = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = '0;

        if (i_cfg_wr_en) begin
            n_table_size = i_cfg_wr_data;
        end
        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == IDX_W'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    n_op         = i_opcode;
                    n_key        = i_key;
                    n_pay        = i_payload_in;
                    n_size       = eff_size;
                    n_res_status = lpht_pkg::ST_OK;
                    n_res_pay    = '0;
                    n_res_slot   = '0;
                    if (i_opcode == lpht_pkg::OP_INSERT) begin
                        rem_start = 1'b1;
                        n_state   = S_DIV;
                    end else if (i_opcode == lpht_pkg::OP_DELETE ||
                                 i_opcode == lpht_pkg::OP_SEARCH) begin
                        if (r_count == '0) begin
                            n_res_status = lpht_pkg::ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            rem_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (rem_st.done) begin
                    n_idx   = rem_w[IDX_W-1:0];
                    n_left  = r_size;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    n_res_slot = idx_w[lpht_pkg::SLOT_W-1:0];
                    n_state    = S_DONE;
                    if (r_op == lpht_pkg::OP_INSERT) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, r_key, r_pay};
                        n_count   = r_count + CNT_W'(1);
                    end else if (r_op == lpht_pkg::OP_DELETE) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b0, r_key, rd_pay};
                        n_count   = r_count - CNT_W'(1);
                    end else begin
                        n_res_pay = rd_pay;
                    end
                end else if (r_left == lpht_pkg::SIZE_W'(1)) begin
                    n_res_status = (r_op == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL
                                                                 : lpht_pkg::ST_NOTFOUND;
                    n_state      = S_DONE;
                end else begin
                    n_idx   = idx_next;
                    n_left  = r_left - 1'b1;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                // move into the output register once it is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pay    = r_res_pay;
                    n_out_slot   = r_res_slot;
                    n_out_occ    = r_count[lpht_pkg::OCC_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_table_size <= lpht_pkg::SIZE_W'(256);
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_table_size <= n_table_size;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_pay        <= n_pay;
        r_size       <= n_size;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_pay    <= n_res_pay;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_pay    <= n_out_pay;
        r_out_slot   <= n_out_slot;
        r_out_occ    <= n_out_occ;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_payload_out = r_out_pay;
    assign o_slot        = r_out_slot;
    assign o_occupied    = r_out_occ;

`ifndef NO_ASSERTIONS
    // an accepted request closes the input until it has finished
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("input not stalled after a request was taken");

    // the entry count never runs past the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SLOTS))
        else $error("entry count above table depth");

    // the count moves only on a hit in the compare step
    a_count_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && !hit) |=> $stable(r_count))
        else $error("entry count changed without a hit");

    // probes never leave the active part of the table
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (idx_w < size_w))
        else $error("probe index outside the table");

    // failures report slot zero and no payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != lpht_pkg::ST_OK) |->
            (r_out_slot == '0 && r_out_pay == '0))
        else $error("failed request carries slot or payload");
`endif

endmodule

// ===== verif/linear_probe_hash_table_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linear_probe_hash_table_core: insert, delete and search
// transactions against a behavioural copy of the table. Needs lpht_pkg and the core RTL.
module linear_probe_hash_table_core_test;

    localparam int          MAX_SLOTS   = 256;
    localparam int unsigned STALL_LIMIT = 5000;  // cycles with no transaction on either side
    localparam int unsigned DRAIN_WAIT  = 40;
    // the one opcode the core ignores; not named in the package
    localparam logic [lpht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [lpht_pkg::OP_W-1:0]  op;
        logic [lpht_pkg::KEY_W-1:0] key;
        logic [lpht_pkg::PAY_W-1:0] pay;
    } t_request;

    typedef struct packed {
        logic [lpht_pkg::ST_W-1:0]   status;
        logic [lpht_pkg::PAY_W-1:0]  payload;
        logic [lpht_pkg::SLOT_W-1:0] slot;
        logic [lpht_pkg::OCC_W-1:0]  occupied;
    } t_reply;

    // DUT connections, inputs all known from time zero
    logic                          i_clk         = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          cfg_wr_en     = 1'b0;
    logic [lpht_pkg::SIZE_W-1:0]   cfg_wr_data   = '0;
    logic                          in_valid      = 1'b0;
    logic [lpht_pkg::OP_W-1:0]     opcode        = '0;
    logic [lpht_pkg::KEY_W-1:0]    key           = '0;
    logic [lpht_pkg::PAY_W-1:0]    payload_in    = '0;
    logic                          out_stall     = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [lpht_pkg::ST_W-1:0]     o_status;
    logic [lpht_pkg::PAY_W-1:0]    o_payload_out;
    logic [lpht_pkg::SLOT_W-1:0]   o_slot;
    logic [lpht_pkg::OCC_W-1:0]    o_occupied;

    linear_probe_hash_table_core #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (opcode),
        .i_key         (key),
        .i_payload_in  (payload_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_status      (o_status),
        .o_payload_out (o_payload_out),
        .o_slot        (o_slot),
        .o_occupied    (o_occupied)
    );

    // ------------------------------------------------------------------
    // Shadow table: our own copy of the core's state and register
    // ------------------------------------------------------------------
    bit [lpht_pkg::KEY_W-1:0]  slot_key  [MAX_SLOTS];
    bit [lpht_pkg::PAY_W-1:0]  slot_pay  [MAX_SLOTS];
    bit                        slot_used [MAX_SLOTS];
    int unsigned               entries   = 0;
    bit [lpht_pkg::SIZE_W-1:0] size_reg  = 9'd256;   // register value out of reset

    t_request    request_backlog[$];   // waiting to be driven
    t_reply      expected_replies[$];  // predicted, oldest first
    int unsigned total_pushed = 0;
    int unsigned results_seen = 0;
    int unsigned errors       = 0;

    // idling: per-phase switches give stretches with no gaps at all
    bit          in_calm    = 1'b0;
    bit          out_calm   = 1'b0;
    t_request    cur_req;
    bit          holding;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned r;

    // size 0 behaves as 1, anything above the slot count as the slot count
    function automatic int unsigned live_slots();
        if (size_reg == 0)
            return 1;
        if (size_reg > MAX_SLOTS)
            return MAX_SLOTS;
        return size_reg;
    endfunction

    // Walk the whole live table from the home slot; no early stop on a free slot,
    // which is what keeps deletes safe without tombstones.
    function automatic bit probe_walk(input bit [lpht_pkg::KEY_W-1:0] k,
                                      input bit want_free, output int unsigned at);
        int unsigned n;
        int unsigned idx;
        n   = live_slots();
        idx = k % n;
        at  = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (want_free ? !slot_used[idx] : (slot_used[idx] && slot_key[idx] == k)) begin
                at = idx;
                return 1'b1;
            end
            idx = (idx + 1 == n) ? 0 : idx + 1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow table and return the reply it should produce
    function automatic t_reply table_update(t_request rq);
        t_reply      rp;
        int unsigned at;
        rp = '0;
        rp.status = lpht_pkg::ST_OK;
        case (rq.op)
            lpht_pkg::OP_INSERT: begin
                // duplicates allowed: just the first free slot
                if (probe_walk(rq.key, 1'b1, at)) begin
                    slot_key[at]  = rq.key;
                    slot_pay[at]  = rq.pay;
                    slot_used[at] = 1'b1;
                    entries++;
                    rp.slot = at[lpht_pkg::SLOT_W-1:0];
                end else begin
                    rp.status = lpht_pkg::ST_FULL;
                end
            end
            lpht_pkg::OP_DELETE, lpht_pkg::OP_SEARCH: begin
                if (entries == 0) begin
                    rp.status = lpht_pkg::ST_EMPTY;
                end else if (probe_walk(rq.key, 1'b0, at)) begin
                    rp.slot = at[lpht_pkg::SLOT_W-1:0];
                    if (rq.op == lpht_pkg::OP_DELETE) begin
                        slot_used[at] = 1'b0;
                        entries--;
                    end else begin
                        rp.payload = slot_pay[at];
                    end
                end else begin
                    rp.status = lpht_pkg::ST_NOTFOUND;
                end
            end
            default: ;  // unused opcode leaves the table alone
        endcase
        rp.occupied = entries[lpht_pkg::OCC_W-1:0];
        return rp;
    endfunction

    function automatic int unsigned pick_gap(bit calm);
        int unsigned p;
        if (calm)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request driver: takes from the backlog, holds the payload steady
    // while stalled, and predicts the reply at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            holding = in_valid;
            if (in_valid && !o_in_stall) begin
                expected_replies.push_back(table_update(cur_req));
                holding = 1'b0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_backlog.size() > 0) begin
                    cur_req     = request_backlog.pop_front();
                    opcode     <= cur_req.op;
                    key        <= cur_req.key;
                    payload_in <= cur_req.pay;
                    holding     = 1'b1;
                    gap_left    = pick_gap(in_calm);
                end
            end
            in_valid <= holding;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, mostly short bursts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (out_calm) begin
            out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                out_stall <= 1'b0;
            end else begin
                stall_left = (r < 90) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                out_stall <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reply want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_replies.size() == 0) begin
                $error("result transaction with nothing outstanding");
                errors++;
            end else begin
                want = expected_replies.pop_front();
                results_seen++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_payload_out !== want.payload) begin
                    $error("payload_out: expected 0x%08h, got 0x%08h",
                           want.payload, o_payload_out);
                    errors++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    errors++;
                end
                if (o_occupied !== want.occupied) begin
                    $error("occupied: expected %0d, got %0d", want.occupied, o_occupied);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction means the core has hung
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $error("no transaction for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [lpht_pkg::OP_W-1:0] op,
                                 input logic [lpht_pkg::KEY_W-1:0] k,
                                 input logic [lpht_pkg::PAY_W-1:0] p);
        request_backlog.push_back('{op: op, key: k, pay: p});
        total_pushed++;
    endtask

    // register writes only once every reply is home
    task automatic settle_and_resize(input bit [lpht_pkg::SIZE_W-1:0] v);
        while (results_seen != total_pushed)
            @(posedge i_clk);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        size_reg     = v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Keys come mostly from a small per-phase pool sized to the table, so that
    // hits, collisions, duplicates and full tables all turn up; the rest are noise.
    task automatic random_phase(input int unsigned count);
        bit [lpht_pkg::KEY_W-1:0]   pool[$];
        int unsigned                n;
        int unsigned                pool_n;
        int unsigned                p;
        logic [lpht_pkg::OP_W-1:0]  op;
        logic [lpht_pkg::KEY_W-1:0] k;
        n      = live_slots();
        pool_n = n + n / 2 + 2;
        if (pool_n > 32)
            pool_n = 32;
        for (int unsigned i = 0; i < pool_n; i++)
            pool.push_back($urandom_range(0, 1) ? lpht_pkg::KEY_W'($urandom)
                                                : lpht_pkg::KEY_W'($urandom_range(0, 4 * n)));
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < count; i++) begin
            p  = $urandom_range(0, 99);
            op = (p < 40) ? lpht_pkg::OP_INSERT :
                 (p < 65) ? lpht_pkg::OP_DELETE :
                 (p < 95) ? lpht_pkg::OP_SEARCH : OP_UNUSED;
            k  = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)]
                                               : lpht_pkg::KEY_W'($urandom);
            queue_request(op, k, $urandom);
        end
    endtask

    initial begin
        bit [lpht_pkg::SIZE_W-1:0] sizes [12];
        int unsigned               counts[12];
        sizes  = '{9'd1, 9'd2, 9'd4, 9'd7, 9'd16, 9'd0,
                   9'd64, 9'd256, 9'd511, 9'd3, 9'd100, 9'd5};
        counts = '{60, 100, 150, 150, 200, 30,
                   180, 120, 50, 100, 60, 50};

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        // Full-size table from reset: empty table, extreme keys and payloads,
        // a duplicate key, absent key and the unused opcode.
        queue_request(lpht_pkg::OP_SEARCH, 31'd0, 32'd0);
        queue_request(lpht_pkg::OP_DELETE, 31'd0, 32'hFFFF_FFFF);
        queue_request(lpht_pkg::OP_INSERT, 31'd0, 32'd0);
        queue_request(lpht_pkg::OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(lpht_pkg::OP_INSERT, 31'd0, 32'hA5A5_A5A5);
        queue_request(lpht_pkg::OP_SEARCH, 31'd0, 32'd0);
        queue_request(lpht_pkg::OP_DELETE, 31'd0, 32'd0);
        queue_request(lpht_pkg::OP_SEARCH, 31'd0, 32'd0);       // now finds the second copy
        queue_request(lpht_pkg::OP_SEARCH, 31'd12345, 32'd0);
        queue_request(OP_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(lpht_pkg::OP_DELETE, 31'd0, 32'd0);
        queue_request(lpht_pkg::OP_DELETE, 31'h7FFF_FFFF, 32'd0);

        // size zero acts as a single slot: second insert finds it full
        settle_and_resize(9'd0);
        queue_request(lpht_pkg::OP_INSERT, 31'd5, 32'd1);
        queue_request(lpht_pkg::OP_INSERT, 31'd6, 32'd2);
        queue_request(lpht_pkg::OP_SEARCH, 31'd6, 32'd0);
        queue_request(lpht_pkg::OP_SEARCH, 31'd5, 32'd0);
        queue_request(lpht_pkg::OP_DELETE, 31'd5, 32'd0);

        // oversize register clamps; then shrink and lose sight of high slots
        settle_and_resize(9'd511);
        queue_request(lpht_pkg::OP_INSERT, 31'd511, 32'h1234_5678);
        queue_request(lpht_pkg::OP_INSERT, 31'd300, 32'h8765_4321);
        settle_and_resize(9'd16);
        queue_request(lpht_pkg::OP_SEARCH, 31'd511, 32'd0);
        queue_request(lpht_pkg::OP_INSERT, 31'd15, 32'h0F0F_0F0F);
        queue_request(lpht_pkg::OP_SEARCH, 31'd300, 32'd0);
        settle_and_resize(9'd256);
        queue_request(lpht_pkg::OP_DELETE, 31'd511, 32'd0);
        queue_request(lpht_pkg::OP_DELETE, 31'd300, 32'd0);
        queue_request(lpht_pkg::OP_DELETE, 31'd15, 32'd0);

        for (int i = 0; i < 12; i++) begin
            settle_and_resize(sizes[i]);
            random_phase(counts[i]);
        end

        while (results_seen != total_pushed)
            @(posedge i_clk);
        // catch any stray result after the last one
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_replies.size() != 0) begin
            $error("%0d predicted results never arrived", expected_replies.size());
            errors++;
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
